### rtl/awf_pkg.sv
// Shared types and constants for the audio output word formatter.
// Holds the sample width, mode and register index codes, and the lane and beat structs.
// No dependencies.
package awf_pkg;

  // Width of the incoming left and right samples.
  localparam int INPUT_BITS = 20;
  // Internal width for sample compares; one bit above the input keeps 16-bit limits exact.
  localparam int EXT_W = INPUT_BITS + 1;

  typedef enum logic [1:0] {
    MODE_I2S  = 2'd0,
    MODE_PWM  = 2'd1,
    MODE_SD   = 2'd2,
    MODE_RSVD = 2'd3
  } mode_t;

  localparam logic [2:0] REG_OUTPUT_MODE  = 3'd0;
  localparam logic [2:0] REG_STEREO       = 3'd1;
  localparam logic [2:0] REG_DITHER_0_3   = 3'd2;
  localparam logic [2:0] REG_DITHER_4_7   = 3'd3;
  localparam logic [2:0] REG_DITHER_8_11  = 3'd4;
  localparam logic [2:0] REG_DITHER_12_15 = 3'd5;

  localparam logic [1:0] LAST_PHASE = 2'd3;

  localparam logic [31:0] PWM_FULL_HIGH = 32'hffff00ff;
  localparam logic [31:0] PWM_FULL_LOW  = 32'h0000ff00;

  // Sixteen 16-bit dither patterns, four per register, low pattern first.
  typedef logic [3:0][63:0] dither_t;

  typedef struct packed {
    logic sd_step;   // update the level for this beat
    logic sd_push;   // shift the new byte into the pending bytes
    logic sd_flush;  // the word is complete, clear the pending bytes
  } lane_ctrl_t;

  typedef struct packed {
    logic [15:0] sat_half;
    logic [31:0] pwm_word;
    logic [31:0] sd_word;
  } lane_res_t;

  typedef struct packed {
    logic [31:0] left_word;
    logic [31:0] right_word;
    logic        right_valid;
  } out_beat_t;

endpackage

### rtl/audio_output_word_formatter_core.sv
// Top level of the audio output word formatter: configuration registers, two channel
// lanes, the merging stage and the output register. Depends on awf_pkg, awf_lane and
// awf_merge.
//
// Usage:
// Each input beat carries one mixed frame (left_sample, right_sample). In I2S and PWM
// modes every frame yields one output beat; in sigma-delta mode every fourth frame
// yields one beat holding four step bytes per channel, oldest in the high byte.
// Reserved mode 3 swallows frames and changes nothing.
// The left and right lanes work side by side on the two samples in the same cycle,
// and the merging stage picks the words for the current mode.
// A result is visible on the output the cycle after its frame is accepted. Throughput
// is one frame per cycle while out_ready is high, set by the single output register.
// When the receiver stalls, the output register holds its beat and a new frame is
// still taken in the same cycle the waiting beat leaves; in_ready drops only while a
// beat waits and out_ready is low.
// The configuration channel is always ready; write it only while the block is idle.
// Reset selects PWM mode in stereo, clears all dither patterns, the sigma-delta
// levels, the pending bytes and the pack phase, and empties the output register.
module audio_output_word_formatter_core (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic signed [awf_pkg::INPUT_BITS-1:0] left_sample,
  input  logic signed [awf_pkg::INPUT_BITS-1:0] right_sample,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [31:0]                         left_word,
  output logic [31:0]                         right_word,
  output logic                                right_valid,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [2:0]                          cfg_index,
  input  logic [63:0]                         cfg_data
);

  awf_pkg::mode_t      mode;
  logic                stereo;
  awf_pkg::dither_t    dither;
  logic [1:0]          phase;
  logic                in_acc;
  logic                sd_acc;
  logic                last;
  awf_pkg::lane_ctrl_t left_ctrl;
  awf_pkg::lane_ctrl_t right_ctrl;
  awf_pkg::lane_res_t  left_res;
  awf_pkg::lane_res_t  right_res;
  awf_pkg::out_beat_t  beat;
  logic                produce;

  // Configuration writes are always taken.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mode   <= awf_pkg::MODE_PWM;
      stereo <= 1'b1;
      dither <= '0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        awf_pkg::REG_OUTPUT_MODE:  mode      <= awf_pkg::mode_t'(cfg_data[1:0]);
        awf_pkg::REG_STEREO:       stereo    <= cfg_data[0];
        awf_pkg::REG_DITHER_0_3:   dither[0] <= cfg_data;
        awf_pkg::REG_DITHER_4_7:   dither[1] <= cfg_data;
        awf_pkg::REG_DITHER_8_11:  dither[2] <= cfg_data;
        awf_pkg::REG_DITHER_12_15: dither[3] <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  // A frame can enter whenever the output register is empty or is being emptied.
  assign in_ready = !out_valid || out_ready;
  assign in_acc   = in_valid && in_ready;
  assign sd_acc   = in_acc && (mode == awf_pkg::MODE_SD);
  assign last     = (phase == awf_pkg::LAST_PHASE);

  // The right lane only advances its sigma-delta state in stereo.
  assign left_ctrl.sd_step   = sd_acc;
  assign left_ctrl.sd_push   = sd_acc && !last;
  assign left_ctrl.sd_flush  = sd_acc && last;
  assign right_ctrl.sd_step  = sd_acc && stereo;
  assign right_ctrl.sd_push  = sd_acc && stereo && !last;
  assign right_ctrl.sd_flush = sd_acc && stereo && last;

  awf_lane u_left_lane (
    .clk    (clk),
    .rst    (rst),
    .sample (left_sample),
    .dither (dither),
    .ctrl   (left_ctrl),
    .res    (left_res)
  );

  awf_lane u_right_lane (
    .clk    (clk),
    .rst    (rst),
    .sample (right_sample),
    .dither (dither),
    .ctrl   (right_ctrl),
    .res    (right_res)
  );

  awf_merge u_merge (
    .left_res  (left_res),
    .right_res (right_res),
    .mode      (mode),
    .stereo    (stereo),
    .phase     (phase),
    .beat      (beat),
    .produce   (produce)
  );

  // Pack phase counts sigma-delta frames and wraps after the fourth.
  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= 2'd0;
    end else if (sd_acc) begin
      phase <= phase + 2'd1;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (in_acc && produce) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && produce) begin
      left_word   <= beat.left_word;
      right_word  <= beat.right_word;
      right_valid <= beat.right_valid;
    end
  end

  // A beat without a right word always carries zero there.
  a_right_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !right_valid |-> right_word == 32'd0)
    else $error("right_word nonzero while right_valid is low");

  // I2S and PWM frames always produce a beat in the next cycle.
  a_direct_beat: assert property (@(posedge clk) disable iff (rst)
    in_acc && (mode == awf_pkg::MODE_I2S || mode == awf_pkg::MODE_PWM) |=> out_valid)
    else $error("I2S or PWM frame did not produce a beat");

  // A sigma-delta frame before the fourth creates no beat.
  a_sd_no_beat: assert property (@(posedge clk) disable iff (rst)
    sd_acc && !last |=> out_valid == $past(out_valid && !out_ready))
    else $error("sigma-delta frame produced a beat before the word was full");

  // I2S frames never carry a right word.
  a_i2s_no_right: assert property (@(posedge clk) disable iff (rst)
    in_acc && mode == awf_pkg::MODE_I2S |=> !right_valid)
    else $error("I2S beat flagged a right word");

endmodule

### rtl/awf_lane.sv
// One channel lane of the audio output word formatter.
// Computes the saturated I2S half, the PWM word and the sigma-delta byte for one sample,
// and holds that channel's sigma-delta level and pending bytes. Depends on awf_pkg.
module awf_lane (
  input  logic                                clk,
  input  logic                                rst,
  input  logic signed [awf_pkg::INPUT_BITS-1:0] sample,
  input  awf_pkg::dither_t                    dither,
  input  awf_pkg::lane_ctrl_t                 ctrl,
  output awf_pkg::lane_res_t                  res
);

  localparam logic signed [awf_pkg::EXT_W-1:0] POS_MAX = awf_pkg::EXT_W'(32'sh7fff);
  localparam logic signed [awf_pkg::EXT_W-1:0] NEG_MIN = awf_pkg::EXT_W'(-32'sh8000);
  localparam logic signed [16:0] STEP_MAX = 17'sd127;
  localparam logic signed [16:0] STEP_MIN = -17'sd127;

  logic signed [15:0]              level;
  logic signed [15:0]              level_next;
  logic [23:0]                     pending;
  logic [23:0]                     pending_next;
  logic signed [awf_pkg::EXT_W-1:0] s_ext;
  logic signed [awf_pkg::EXT_W-1:0] t_ext;
  logic                            over;
  logic                            under;
  logic [15:0]                     u;
  logic [15:0]                     pattern;
  logic signed [15:0]              target;
  logic signed [16:0]              diff;
  logic [6:0]                      mag;
  logic [7:0]                      sd_byte;

  assign s_ext = awf_pkg::EXT_W'(sample);
  assign over  = s_ext > POS_MAX;
  assign under = s_ext < NEG_MIN;

  // Saturated half for I2S.
  always_comb begin
    if (over) begin
      res.sat_half = 16'h7fff;
    end else if (under) begin
      res.sat_half = 16'h8000;
    end else begin
      res.sat_half = s_ext[15:0];
    end
  end

  // PWM: offset to unsigned, high byte sets the runs, next nibble picks the dither.
  assign u       = {~s_ext[15], s_ext[14:0]};
  assign pattern = dither[u[7:6]][{u[5:4], 4'b0000} +: 16];

  always_comb begin
    if (over) begin
      res.pwm_word = awf_pkg::PWM_FULL_HIGH;
    end else if (under) begin
      res.pwm_word = awf_pkg::PWM_FULL_LOW;
    end else begin
      res.pwm_word = {pattern, ~u[15:8], u[15:8]};
    end
  end

  // Sigma-delta: floor shift by four, saturate, then a step limited to 127.
  assign t_ext = s_ext >>> 4;

  always_comb begin
    if (t_ext > POS_MAX) begin
      target = 16'sh7fff;
    end else if (t_ext < NEG_MIN) begin
      target = -16'sh8000;
    end else begin
      target = t_ext[15:0];
    end
  end

  assign diff = 17'(target) - 17'(level);

  always_comb begin
    if (!diff[16]) begin
      mag        = (diff > STEP_MAX) ? 7'd127 : diff[6:0];
      sd_byte    = {1'b0, mag};
      level_next = level + 16'(mag);
    end else begin
      mag        = (diff < STEP_MIN) ? 7'd127 : 7'(-diff);
      sd_byte    = {1'b1, mag};
      level_next = level - 16'(mag);
    end
  end

  assign res.sd_word = {pending, sd_byte};

  always_comb begin
    pending_next = pending;
    if (ctrl.sd_flush) begin
      pending_next = 24'd0;
    end else if (ctrl.sd_push) begin
      pending_next = {pending[15:0], sd_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      level   <= 16'sd0;
      pending <= 24'd0;
    end else begin
      if (ctrl.sd_step) begin
        level <= level_next;
      end
      pending <= pending_next;
    end
  end

endmodule

### rtl/awf_merge.sv
// Merging stage of the audio output word formatter.
// Combines the left and right lane results into one output beat by mode and stereo setting.
// Depends on awf_pkg.
module awf_merge (
  input  awf_pkg::lane_res_t left_res,
  input  awf_pkg::lane_res_t right_res,
  input  awf_pkg::mode_t     mode,
  input  logic               stereo,
  input  logic [1:0]         phase,
  output awf_pkg::out_beat_t beat,
  output logic               produce
);

  always_comb begin
    beat    = '0;
    produce = 1'b0;
    unique case (mode)
      awf_pkg::MODE_I2S: begin
        produce        = 1'b1;
        beat.left_word = {stereo ? right_res.sat_half : left_res.sat_half, left_res.sat_half};
      end
      awf_pkg::MODE_PWM: begin
        produce          = 1'b1;
        beat.left_word   = left_res.pwm_word;
        beat.right_word  = stereo ? right_res.pwm_word : 32'd0;
        beat.right_valid = stereo;
      end
      awf_pkg::MODE_SD: begin
        produce          = (phase == awf_pkg::LAST_PHASE);
        beat.left_word   = left_res.sd_word;
        beat.right_word  = stereo ? right_res.sd_word : 32'd0;
        beat.right_valid = stereo;
      end
      default: begin
        produce = 1'b0;
      end
    endcase
  end

endmodule
